[sv/scc_pkg.sv]
// scc_pkg: types, constants and calendar helpers for seconds_count_calendar.
// Used by the split pipeline, the calendar stage and the top level.
`timescale 1ns / 1ps

package scc_pkg;

  typedef enum logic {
    OP_SET  = 1'b0,
    OP_READ = 1'b1
  } scc_op_t;

  localparam logic [31:0] ALL_ONES   = 32'hffff_ffff;
  localparam logic [16:0] DAY_SECS   = 17'd86400;
  localparam logic [16:0] HOUR_SECS  = 17'd3600;
  localparam logic [16:0] MIN_SECS   = 17'd60;
  localparam logic [6:0]  YR_CENT    = 7'd100;

  // floor(x / 675) for x < 2^25: (x * DAY_RECIP) >> DAY_SHIFT
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam int          DAY_SHIFT  = 35;
  // floor(x / 15) for x < 2^16
  localparam logic [15:0] MIN_RECIP  = 16'd34953;
  localparam int          MIN_SHIFT  = 19;
  // floor(x / 15) for x < 512
  localparam logic [9:0]  HOUR_RECIP = 10'd547;
  localparam int          HOUR_SHIFT = 13;
  // floor(x / 25) for x < 4096
  localparam logic [11:0] CENT_RECIP = 12'd2622;
  localparam int          CENT_SHIFT = 16;

  localparam logic [3:0]  MONTH_DEC  = 4'd12;
  localparam logic [6:0]  Y100_LAST  = 7'd99;
  localparam logic [13:0] YEAR_LAST  = 14'h3fff;

  typedef struct packed {
    scc_op_t     op;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [16:0] set_rv;
  } scc_side_t;

  typedef struct packed {
    scc_side_t   side;
    logic [16:0] cnt_lo;
    logic [15:0] quo;
    logic [7:0]  yq;
  } scc_s1_t;

  typedef struct packed {
    scc_side_t   side;
    logic [16:0] rem;
    logic        roll;
    logic [6:0]  y100;
    logic [1:0]  c4;
  } scc_s2_t;

  typedef struct packed {
    scc_side_t   side;
    logic [16:0] rem;
    logic        roll;
    logic [6:0]  y100;
    logic [1:0]  c4;
    logic [10:0] tmin;
  } scc_s3_t;

  typedef struct packed {
    scc_side_t   side;
    logic [16:0] rem;
    logic        roll;
    logic [6:0]  y100;
    logic [1:0]  c4;
    logic [10:0] tmin;
    logic [4:0]  hour;
    logic [5:0]  second;
  } scc_split_t;

  // Gregorian leap test from year bits, year mod 100 and (year / 100) mod 4.
  function automatic logic is_leap(input logic [1:0] ylo, input logic [6:0] y100,
                                   input logic [1:0] c4);
    return ((ylo == 2'd0) && (y100 != 7'd0)) || ((y100 == 7'd0) && (c4 == 2'd0));
  endfunction

  // Last day of a month; zero for a month code outside 1..12.
  function automatic logic [4:0] month_last(input logic [3:0] m, input logic leap);
    logic [4:0] last;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: last = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   last = 5'd30;
      4'd2:                                      last = leap ? 5'd29 : 5'd28;
      default:                                   last = 5'd0;
    endcase
    return last;
  endfunction

endpackage

[sv/scc_split.sv]
// scc_split: four-stage pipeline that splits the seconds count into
// day remainder, hour, minute count and second. Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_split (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [31:0]           count,
  input  logic [4:0]            set_day,
  input  logic [3:0]            set_month,
  input  logic [13:0]           set_year,
  input  logic [4:0]            set_hour,
  input  logic [5:0]            set_minute,
  input  logic [5:0]            set_second,
  output logic                  s_valid,
  input  logic                  s_ready,
  output scc_pkg::scc_split_t   s
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  scc_pkg::scc_s1_t    s1, s1_next;
  scc_pkg::scc_s2_t    s2, s2_next;
  scc_pkg::scc_s3_t    s3, s3_next;
  scc_pkg::scc_split_t s4, s4_next;

  logic [31:0] c_eff;
  logic [50:0] day_prod;
  logic [23:0] cent_prod;
  logic [32:0] day_back;
  logic [13:0] cent_back;
  logic [30:0] min_prod;
  logic [16:0] sec_back;
  logic [18:0] hour_prod;

  assign en4 = !v4 || s_ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign s_valid  = v4;
  assign s        = s4;

  // stage 1: day quotient, set reload sum, century quotient
  always_comb begin
    c_eff     = (count == scc_pkg::ALL_ONES) ? 32'd0 : count;
    day_prod  = 51'(c_eff[31:7]) * 51'(scc_pkg::DAY_RECIP);
    cent_prod = 24'(set_year[13:2]) * 24'(scc_pkg::CENT_RECIP);
    s1_next.side.op     = scc_pkg::scc_op_t'(op);
    s1_next.side.day    = set_day;
    s1_next.side.month  = set_month;
    s1_next.side.year   = set_year;
    s1_next.side.set_rv = 17'(set_hour) * scc_pkg::HOUR_SECS
                        + 17'(set_minute) * scc_pkg::MIN_SECS + 17'(set_second);
    s1_next.cnt_lo = c_eff[16:0];
    s1_next.quo    = day_prod[scc_pkg::DAY_SHIFT +: 16];
    s1_next.yq     = cent_prod[scc_pkg::CENT_SHIFT +: 8];
  end

  // stage 2: remainder of the day, year mod 100
  always_comb begin
    day_back  = 33'(s1.quo) * 33'(scc_pkg::DAY_SECS);
    cent_back = 14'(s1.yq) * 14'(scc_pkg::YR_CENT);
    s2_next.side = s1.side;
    s2_next.rem  = s1.cnt_lo - day_back[16:0];
    s2_next.roll = (s1.quo != 16'd0);
    s2_next.y100 = 7'(s1.side.year - cent_back);
    s2_next.c4   = s1.yq[1:0];
  end

  // stage 3: total minutes of the day
  always_comb begin
    min_prod = 31'(s2.rem[16:2]) * 31'(scc_pkg::MIN_RECIP);
    s3_next.side = s2.side;
    s3_next.rem  = s2.rem;
    s3_next.roll = s2.roll;
    s3_next.y100 = s2.y100;
    s3_next.c4   = s2.c4;
    s3_next.tmin = min_prod[scc_pkg::MIN_SHIFT +: 11];
  end

  // stage 4: hour and second
  always_comb begin
    sec_back  = 17'(s3.tmin) * scc_pkg::MIN_SECS;
    hour_prod = 19'(s3.tmin[10:2]) * 19'(scc_pkg::HOUR_RECIP);
    s4_next.side   = s3.side;
    s4_next.rem    = s3.rem;
    s4_next.roll   = s3.roll;
    s4_next.y100   = s3.y100;
    s4_next.c4     = s3.c4;
    s4_next.tmin   = s3.tmin;
    s4_next.hour   = hour_prod[scc_pkg::HOUR_SHIFT +: 5];
    s4_next.second = 6'(s3.rem - sec_back);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) s1 <= s1_next;
    if (en2) s2 <= s2_next;
    if (en3) s3 <= s3_next;
    if (en4) s4 <= s4_next;
  end

endmodule

[sv/scc_date.sv]
// scc_date: calendar state and result register; sets or advances the date
// and forms the result word. Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_date (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  scc_pkg::scc_split_t s,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [4:0]          day,
  output logic [3:0]          month,
  output logic [13:0]         year,
  output logic [4:0]          hour,
  output logic [5:0]          minute,
  output logic [5:0]          second,
  output logic                reload,
  output logic [16:0]         reload_value
);

  logic [4:0]  cur_day,   cur_day_next;
  logic [3:0]  cur_month, cur_month_next;
  logic [13:0] cur_year,  cur_year_next;
  logic [6:0]  cur_y100,  cur_y100_next;
  logic [1:0]  cur_c4,    cur_c4_next;
  logic        take;
  logic        is_read;
  logic [4:0]  last;
  logic [10:0] hour_min;
  logic [5:0]  min_val;

  assign s_ready = !out_valid || out_ready;
  assign take    = s_valid && s_ready;
  assign is_read = (s.side.op == scc_pkg::OP_READ);

  always_comb begin
    last = scc_pkg::month_last(cur_month,
                               scc_pkg::is_leap(cur_year[1:0], cur_y100, cur_c4));
    cur_day_next   = cur_day;
    cur_month_next = cur_month;
    cur_year_next  = cur_year;
    cur_y100_next  = cur_y100;
    cur_c4_next    = cur_c4;
    if (!is_read) begin
      cur_day_next   = s.side.day;
      cur_month_next = s.side.month;
      cur_year_next  = s.side.year;
      cur_y100_next  = s.y100;
      cur_c4_next    = s.c4;
    end else if (s.roll && (last != 5'd0)) begin
      if (cur_day < last) begin
        cur_day_next = cur_day + 5'd1;
      end else if (cur_month == scc_pkg::MONTH_DEC) begin
        cur_day_next   = 5'd1;
        cur_month_next = 4'd1;
        cur_year_next  = cur_year + 14'd1;
        if (cur_year == scc_pkg::YEAR_LAST) begin
          cur_y100_next = 7'd0;
          cur_c4_next   = 2'd0;
        end else if (cur_y100 == scc_pkg::Y100_LAST) begin
          cur_y100_next = 7'd0;
          cur_c4_next   = cur_c4 + 2'd1;
        end else begin
          cur_y100_next = cur_y100 + 7'd1;
        end
      end else begin
        cur_day_next   = 5'd1;
        cur_month_next = cur_month + 4'd1;
      end
    end
  end

  always_comb begin
    hour_min = 11'(s.hour) * 11'(scc_pkg::MIN_SECS);
    min_val  = 6'(s.tmin - hour_min);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_day   <= 5'd0;
      cur_month <= 4'd0;
      cur_year  <= 14'd0;
      cur_y100  <= 7'd0;
      cur_c4    <= 2'd0;
    end else begin
      if (s_ready) out_valid <= s_valid;
      if (take) begin
        cur_day   <= cur_day_next;
        cur_month <= cur_month_next;
        cur_year  <= cur_year_next;
        cur_y100  <= cur_y100_next;
        cur_c4    <= cur_c4_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      day          <= cur_day_next;
      month        <= cur_month_next;
      year         <= cur_year_next;
      hour         <= is_read ? s.hour : 5'd0;
      minute       <= is_read ? min_val : 6'd0;
      second       <= is_read ? s.second : 6'd0;
      reload       <= !is_read || s.roll;
      reload_value <= !is_read ? s.side.set_rv : (s.roll ? s.rem : 17'd0);
    end
  end

endmodule

[sv/seconds_count_calendar.sv]
// seconds_count_calendar: calendar date kept beside a seconds counter.
// Top level; instantiates scc_split and scc_date, uses scc_pkg.
//
// Input channel (in_valid/in_ready): one word per request. op selects a set
// (store set_day/set_month/set_year, reload counter with the set time) or a
// read (split count into hour/minute/second; a count of one day or more
// advances the date by one day and asks for a reload of count mod 86400).
// Output channel (out_valid/out_ready): one result word per request, in order.
// A result passes the four split stages and then the result register.
// Throughput: one word per cycle while the receiver keeps out_ready high.
// Each stage holds its word while the next one is full; a stalled receiver
// fills the pipeline (up to five words) before in_ready drops.
// Reset clears all stage valid bits and the stored date to zero.
`timescale 1ns / 1ps

module seconds_count_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [31:0] count,
  input  logic [4:0]  set_day,
  input  logic [3:0]  set_month,
  input  logic [13:0] set_year,
  input  logic [4:0]  set_hour,
  input  logic [5:0]  set_minute,
  input  logic [5:0]  set_second,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  day,
  output logic [3:0]  month,
  output logic [13:0] year,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic        reload,
  output logic [16:0] reload_value
);

  logic                s_valid;
  logic                s_ready;
  scc_pkg::scc_split_t s;

  scc_split u_split (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .count      (count),
    .set_day    (set_day),
    .set_month  (set_month),
    .set_year   (set_year),
    .set_hour   (set_hour),
    .set_minute (set_minute),
    .set_second (set_second),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s          (s)
  );

  scc_date u_date (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .s            (s),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .day          (day),
    .month        (month),
    .year         (year),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .reload       (reload),
    .reload_value (reload_value)
  );

endmodule

[sv/scc_checker.sv]
// scc_checker: port-level assertions for seconds_count_calendar.
// Attached to the top level by the bind below; no other dependencies.
`timescale 1ns / 1ps

module scc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  day,
  input logic [3:0]  month,
  input logic [13:0] year,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic        reload,
  input logic [16:0] reload_value
);

  // split time is always a legal time of day
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hour < 5'd24) && (minute < 6'd60) && (second < 6'd60))
    else $error("split time out of range");

  // no reload request means no reload value
  a_no_reload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !reload) |-> (reload_value == 17'd0))
    else $error("reload value without reload");

  // a read that did not roll over keeps the date it had
  a_date_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready ##1 out_valid && !reload)
      |-> (day == $past(day)) && (month == $past(month)) && (year == $past(year)))
    else $error("date changed without rollover");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(reload_value) && $stable(day))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind seconds_count_calendar scc_checker u_scc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .day          (day),
  .month        (month),
  .year         (year),
  .hour         (hour),
  .minute       (minute),
  .second       (second),
  .reload       (reload),
  .reload_value (reload_value)
);
